// ===== hdl/nvs_pkg.sv =====
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared types and constants for the normalized vector sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package nvs_pkg;

   localparam int unsigned CompWidth  = 16;
   localparam int unsigned SumWidth   = 17;
   localparam int unsigned SqWidth    = 35;
   localparam int unsigned RootWidth  = 32;
   localparam int unsigned MagWidth   = 17;
   localparam int unsigned QuotWidth  = 16;
   localparam logic [QuotWidth-1:0] OneQ14 = 16'd16384;

   typedef struct packed {
      logic signed [CompWidth-1:0] ax;
      logic signed [CompWidth-1:0] ay;
      logic signed [CompWidth-1:0] az;
      logic signed [CompWidth-1:0] bx;
      logic signed [CompWidth-1:0] by;
      logic signed [CompWidth-1:0] bz;
   } req_type;

   typedef struct packed {
      logic signed [CompWidth-1:0] hx;
      logic signed [CompWidth-1:0] hy;
      logic signed [CompWidth-1:0] hz;
      logic [MagWidth-1:0]         magnitude;
      logic                        zero_vector;
   } rsp_type;

   typedef struct packed {
      logic [2:0]          neg;
      logic                zero;
      logic [MagWidth-1:0] magnitude;
   } side_type;

endpackage

`default_nettype wire

// ===== hdl/nvs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// nvs_sqrt_cell
// One bit step of a restoring square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nvs_sqrt_cell
   import nvs_pkg::*;
#(
   parameter int unsigned RemWidth = RootWidth + 2,
   parameter int unsigned ResWidth = RootWidth,
   parameter int unsigned PayWidth = 2 * RootWidth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                valid_in,
   input  wire logic [1:0]          pair_in,
   input  wire logic [RemWidth-1:0] rem_in,
   input  wire logic [ResWidth-1:0] res_in,
   input  wire logic [PayWidth-1:0] pay_in,
   output logic                     valid_out,
   output logic [RemWidth-1:0]      rem_out,
   output logic [ResWidth-1:0]      res_out,
   output logic [PayWidth-1:0]      pay_out
);

   logic [RemWidth-1:0] shifted;
   logic [RemWidth-1:0] trial;
   logic                fits;
   logic                valid_ff;
   logic [RemWidth-1:0] rem_ff, rem_in_next;
   logic [ResWidth-1:0] res_ff, res_in_next;
   logic [PayWidth-1:0] pay_ff;

   always_comb begin
      shifted     = {rem_in[RemWidth-3:0], pair_in};
      trial       = {res_in[RemWidth-3:0], 2'b01};
      fits        = shifted >= trial;
      rem_in_next = fits ? shifted - trial : shifted;
      res_in_next = {res_in[ResWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         rem_ff <= rem_in_next;
         res_ff <= res_in_next;
         pay_ff <= pay_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign res_out   = res_ff;
   assign pay_out   = pay_ff;

endmodule

`default_nettype wire

// ===== hdl/nvs_div_cell.sv =====
// ----------------------------------------------------------------------------
// nvs_div_cell
// One quotient bit step of three restoring divisions sharing a divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module nvs_div_cell
   import nvs_pkg::*;
#(
   parameter int unsigned DenWidth = RootWidth,
   parameter int unsigned NumWidth = QuotWidth,
   parameter int unsigned PayWidth = $bits(side_type)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     valid_in,
   input  wire logic [DenWidth-1:0]      den_in,
   input  wire logic [2:0][NumWidth-1:0] num_in,
   input  wire logic [2:0][DenWidth-1:0] rem_in,
   input  wire logic [2:0][NumWidth-1:0] quo_in,
   input  wire logic [PayWidth-1:0]      pay_in,
   output logic                          valid_out,
   output logic [DenWidth-1:0]           den_out,
   output logic [2:0][NumWidth-1:0]      num_out,
   output logic [2:0][DenWidth-1:0]      rem_out,
   output logic [2:0][NumWidth-1:0]      quo_out,
   output logic [PayWidth-1:0]           pay_out
);

   logic [2:0][DenWidth:0]    part;
   logic [2:0]                fits;
   logic                      valid_ff;
   logic [DenWidth-1:0]       den_ff;
   logic [2:0][NumWidth-1:0]  num_ff;
   logic [2:0][DenWidth-1:0]  rem_ff;
   logic [2:0][NumWidth-1:0]  quo_ff;
   logic [PayWidth-1:0]       pay_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         part[i] = {rem_in[i], num_in[i][NumWidth-1]};
         fits[i] = part[i] >= {1'b0, den_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         den_ff <= den_in;
         pay_ff <= pay_in;
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {num_in[i][NumWidth-2:0], 1'b0};
            rem_ff[i] <= fits[i] ? DenWidth'(part[i] - {1'b0, den_in})
                                 : part[i][DenWidth-1:0];
            quo_ff[i] <= {quo_in[i][NumWidth-2:0], fits[i]};
         end
      end
   end

   assign valid_out = valid_ff;
   assign den_out   = den_ff;
   assign num_out   = num_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign pay_out   = pay_ff;

endmodule

`default_nettype wire

// ===== hdl/normalized_vector_sum_3d.sv =====
// ----------------------------------------------------------------------------
// normalized_vector_sum_3d
// Normalized sum of two signed 3D vectors, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: the req channel takes two vectors per transaction, the rsp channel
// returns the unit sum in Q1.14, the integer magnitude and a zero flag.
// Both use valid/ready. One transaction is accepted every cycle unless the output stalls.
// The pipeline holds 52 registers: the sum and square stage, the squared
// length stage, a row of 32 square root cells (one result bit each), the
// numerator stage, a row of 16 shared division cells and an output register.
// When rsp_valid is high and rsp_ready is low the whole pipeline freezes and
// req_ready drops, so a transaction already in flight is held in place and
// never lost.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_vector_sum_3d
   import nvs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned RadWidth = 2 * RootWidth;
   localparam int unsigned RemW     = RootWidth + 2;
   localparam int unsigned FracBits = 28;
   localparam int unsigned MagShift = 14;
   localparam int unsigned SumsW    = 3 * SumWidth;
   localparam int unsigned SPayW    = RadWidth + SumsW;
   localparam int unsigned NumW     = SumWidth + FracBits + 1;
   localparam int unsigned SideW    = $bits(side_type);

   // Pipeline advances only when the output can move.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Stage 0: component sums and squares.
   logic signed [SumWidth-1:0] sx, sy, sz;
   assign sx = SumWidth'(req_data.ax) + SumWidth'(req_data.bx);
   assign sy = SumWidth'(req_data.ay) + SumWidth'(req_data.by);
   assign sz = SumWidth'(req_data.az) + SumWidth'(req_data.bz);

   logic signed [SqWidth-1:0] wx, wy, wz;
   logic [SqWidth-1:0]        sqx, sqy, sqz;
   always_comb begin
      wx  = SqWidth'(sx);
      wy  = SqWidth'(sy);
      wz  = SqWidth'(sz);
      sqx = wx * wx;
      sqy = wy * wy;
      sqz = wz * wz;
   end

   logic                     s0_valid_ff;
   logic [2:0][SumWidth-1:0] s0_sum_ff;
   logic [2:0][SqWidth-1:0]  sq_ff;
   logic                     s1_valid_ff;
   logic [2:0][SumWidth-1:0] s1_sum_ff;
   logic [SqWidth-1:0]       q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
      end
      if (adv) begin
         s0_sum_ff[0] <= sx;
         s0_sum_ff[1] <= sy;
         s0_sum_ff[2] <= sz;
         sq_ff[0]     <= sqx;
         sq_ff[1]     <= sqy;
         sq_ff[2]     <= sqz;
         s1_sum_ff    <= s0_sum_ff;
         q_ff         <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   // Square root chain over Q * 2^28 (64-bit radicand, 32 result bits).
   logic [RadWidth-1:0] rad;
   assign rad = {1'b0, q_ff, {FracBits{1'b0}}};

   logic                 sv   [RootWidth+1];
   logic [RemW-1:0]      srem [RootWidth+1];
   logic [RootWidth-1:0] sres [RootWidth+1];
   logic [SPayW-1:0]     spay [RootWidth+1];

   assign sv[0]   = s1_valid_ff;
   assign srem[0] = '0;
   assign sres[0] = '0;
   assign spay[0] = {rad, s1_sum_ff};

   genvar g;
   generate
      for (g = 0; g < RootWidth; g++) begin : g_sqrt
         nvs_sqrt_cell #(
            .RemWidth(RemW), .ResWidth(RootWidth), .PayWidth(SPayW)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(adv),
            .valid_in(sv[g]), .pair_in(spay[g][SPayW-1-2*g -: 2]),
            .rem_in(srem[g]), .res_in(sres[g]), .pay_in(spay[g]),
            .valid_out(sv[g+1]), .rem_out(srem[g+1]), .res_out(sres[g+1]),
            .pay_out(spay[g+1])
         );
      end
   endgenerate

   // Numerator stage: |c| * 2^28 + R / 2 for each component.
   logic [RootWidth-1:0]     root;
   logic [2:0][SumWidth-1:0] root_sums;
   logic [2:0][SumWidth-1:0] c_abs;
   logic [2:0][NumW-1:0]     c_num;
   logic [2:0]               c_neg;
   side_type                 side_in;

   assign root      = sres[RootWidth];
   assign root_sums = spay[RootWidth][SumsW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_neg[i] = root_sums[i][SumWidth-1];
         c_abs[i] = c_neg[i] ? -root_sums[i] : root_sums[i];
         c_num[i] = NumW'({c_abs[i], {FracBits{1'b0}}}) + NumW'(root[RootWidth-1:1]);
      end
      side_in.neg       = c_neg;
      side_in.zero      = (root == '0);
      side_in.magnitude = root[MagShift+MagWidth-1:MagShift];
   end

   logic                       d_valid_ff;
   logic [RootWidth-1:0]       d_den_ff;
   logic [2:0][QuotWidth-1:0]  d_num_ff;
   logic [2:0][RootWidth-1:0]  d_rem_ff;
   side_type                   d_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= sv[RootWidth];
      end
      if (adv) begin
         d_den_ff  <= root;
         d_side_ff <= side_in;
         for (int i = 0; i < 3; i++) begin
            d_num_ff[i] <= c_num[i][QuotWidth-1:0];
            d_rem_ff[i] <= RootWidth'(c_num[i][NumW-1:QuotWidth]);
         end
      end
   end

   // Division chain, one quotient bit per cell.
   logic                      dv   [QuotWidth+1];
   logic [RootWidth-1:0]      dden [QuotWidth+1];
   logic [2:0][QuotWidth-1:0] dnum [QuotWidth+1];
   logic [2:0][RootWidth-1:0] drem [QuotWidth+1];
   logic [2:0][QuotWidth-1:0] dquo [QuotWidth+1];
   logic [SideW-1:0]          dpay [QuotWidth+1];

   assign dv[0]   = d_valid_ff;
   assign dden[0] = d_den_ff;
   assign dnum[0] = d_num_ff;
   assign drem[0] = d_rem_ff;
   assign dquo[0] = '0;
   assign dpay[0] = d_side_ff;

   generate
      for (g = 0; g < QuotWidth; g++) begin : g_div
         nvs_div_cell #(
            .DenWidth(RootWidth), .NumWidth(QuotWidth), .PayWidth(SideW)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(adv),
            .valid_in(dv[g]), .den_in(dden[g]), .num_in(dnum[g]),
            .rem_in(drem[g]), .quo_in(dquo[g]), .pay_in(dpay[g]),
            .valid_out(dv[g+1]), .den_out(dden[g+1]), .num_out(dnum[g+1]),
            .rem_out(drem[g+1]), .quo_out(dquo[g+1]), .pay_out(dpay[g+1])
         );
      end
   endgenerate

   // Output stage: saturation, sign and the zero vector.
   side_type                  out_side;
   logic [2:0][QuotWidth-1:0] out_quo;
   logic [QuotWidth-1:0]      h_mag;
   logic [2:0][QuotWidth-1:0] h_val;
   rsp_type                   result_in;
   rsp_type                   result_ff;
   logic                      result_valid_ff;

   assign out_side = dpay[QuotWidth];
   assign out_quo  = dquo[QuotWidth];

   always_comb begin
      h_mag = '0;
      for (int i = 0; i < 3; i++) begin
         h_mag    = (out_quo[i] > OneQ14) ? OneQ14 : out_quo[i];
         h_val[i] = out_side.neg[i] ? -h_mag : h_mag;
      end
      result_in.hx          = out_side.zero ? '0 : h_val[0];
      result_in.hy          = out_side.zero ? '0 : h_val[1];
      result_in.hz          = out_side.zero ? '0 : h_val[2];
      result_in.magnitude   = out_side.magnitude;
      result_in.zero_vector = out_side.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (adv) begin
         result_valid_ff <= dv[QuotWidth];
      end
      if (adv) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = result_valid_ff;
   assign rsp_data  = result_ff;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the normalized vector sum block. Directed corner
// vectors and random vector pairs are sent under several idle and stall
// patterns; every result is compared against an integer model of the unit sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench
   import nvs_pkg::*;
();

   localparam int unsigned Latency    = 52;
   localparam longint      CycleLimit = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_units[$];
   int      error_count = 0;
   longint  cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_off_cycles = 0;

   normalized_vector_sum_3d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (x >= root + bit_val) begin
            x = x - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   function automatic logic [15:0] unit_q14(input longint c, input logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] h;
      mag = (c < 0) ? -c : c;
      h = ((mag << 28) + (len >> 1)) / len;
      if (h > OneQ14) h = OneQ14;
      if (c < 0) h = -h;
      return h[15:0];
   endfunction

   function automatic rsp_type predict_unit_sum(input req_type r);
      rsp_type     res;
      longint      sx, sy, sz;
      logic [63:0] sq;
      logic [63:0] root;
      res = '0;
      sx = longint'(r.ax) + longint'(r.bx);
      sy = longint'(r.ay) + longint'(r.by);
      sz = longint'(r.az) + longint'(r.bz);
      sq = sx * sx + sy * sy + sz * sz;
      if (sq == 0) begin
         res.zero_vector = 1'b1;
      end else begin
         res.hx = unit_q14(sx, int_sqrt(sq << 28));
         res.hy = unit_q14(sy, int_sqrt(sq << 28));
         res.hz = unit_q14(sz, int_sqrt(sq << 28));
         root = int_sqrt(sq);
         res.magnitude = root[MagWidth-1:0];
      end
      return res;
   endfunction

   task automatic send_vectors(input req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      expected_units.push_back(predict_unit_sum(r));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_pair(input int ax, ay, az, bx, by, bz);
      req_type r;
      r.ax = CompWidth'(ax); r.ay = CompWidth'(ay); r.az = CompWidth'(az);
      r.bx = CompWidth'(bx); r.by = CompWidth'(by); r.bz = CompWidth'(bz);
      send_vectors(r);
   endtask

   function automatic logic [15:0] random_comp();
      case ($urandom_range(5))
         0: return CompWidth'(16'h8000 + $urandom_range(3));
         1: return CompWidth'(16'h7FFF - $urandom_range(3));
         2: return CompWidth'($urandom_range(6) - 3);
         3: return CompWidth'($urandom_range(600) - 300);
         default: return CompWidth'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      req_type r;
      repeat (count) begin
         r.ax = random_comp(); r.ay = random_comp(); r.az = random_comp();
         case ($urandom_range(3))
            0: begin
               r.bx = '0; r.by = '0; r.bz = '0;
            end
            1: begin
               r.bx = CompWidth'(-r.ax + $urandom_range(2) - 1);
               r.by = CompWidth'(-r.ay + $urandom_range(2) - 1);
               r.bz = CompWidth'(-r.az + $urandom_range(2) - 1);
            end
            default: begin
               r.bx = random_comp(); r.by = random_comp(); r.bz = random_comp();
            end
         endcase
         send_vectors(r);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_vectors();
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(5, -7, 9, -5, 7, -9);
      send_pair(1, 0, 0, 0, 0, 0);
      send_pair(0, -1, 0, 0, 0, 0);
      send_pair(0, 0, 0, 0, 0, 1);
      send_pair(32767, 32767, 32767, 32767, 32767, 32767);
      send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
      send_pair(-32768, 32767, -32768, 32767, -32768, 32767);
      send_pair(32767, 0, 0, 32767, 0, 0);
      send_pair(-32768, 0, 0, -32768, 0, 0);
      send_pair(1, 1, 0, 0, 0, 0);
      send_pair(1, 1, 1, 0, 0, 0);
      send_pair(-1, 1, -1, 0, 0, 0);
      send_pair(3, 4, 0, 0, 0, 0);
      send_pair(-32768, -32768, -32768, 0, 0, 0);
      send_pair(32767, -32768, 1, -1, 0, 0);
      send_pair(2, 3, 6, 0, 0, 0);
      send_pair(1, 2, 2, 1, 2, 2);
      wait_drained();
   endtask

   task automatic test_streaming();
      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(250);
      send_idle_pct = 49; recv_stall_pct = 0;  send_random(220);
      send_idle_pct = 0;  recv_stall_pct = 49; send_random(220);
      send_idle_pct = 20; recv_stall_pct = 20; send_random(220);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0; recv_stall_pct = 0;
      hold_off_cycles = 300;
      send_random(200);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            $error("unexpected transaction: hx=%0d", rsp_data.hx);
            error_count++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_data.hx !== want.hx) begin
               $error("hx: expected %0d, actual %0d", want.hx, rsp_data.hx);
               error_count++;
            end
            if (rsp_data.hy !== want.hy) begin
               $error("hy: expected %0d, actual %0d", want.hy, rsp_data.hy);
               error_count++;
            end
            if (rsp_data.hz !== want.hz) begin
               $error("hz: expected %0d, actual %0d", want.hz, rsp_data.hz);
               error_count++;
            end
            if (rsp_data.magnitude !== want.magnitude) begin
               $error("magnitude: expected %0d, actual %0d",
                      want.magnitude, rsp_data.magnitude);
               error_count++;
            end
            if (rsp_data.zero_vector !== want.zero_vector) begin
               $error("zero_vector: expected %0b, actual %0b",
                      want.zero_vector, rsp_data.zero_vector);
               error_count++;
            end
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("** normalized_vector_sum_3d: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_vectors();
      test_streaming();
      test_backpressure();
      repeat (2 * Latency) @(posedge clock);
      if (error_count == 0 && expected_units.size() == 0) begin
         $display("** normalized_vector_sum_3d: PASSED **");
      end else begin
         $display("** normalized_vector_sum_3d: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
